// File: hw/rtl/barp_pkg.sv
// ----------------------------------------------------------------------------
// barp_pkg
// Shared types, key codes and register indexes of the button panel core.
// ----------------------------------------------------------------------------
package barp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [5:0] REPEAT_MAX = 6'd63;

	typedef enum logic [1:0] {
		KEY_NONE = 2'd0,
		KEY_UP   = 2'd1,
		KEY_DOWN = 2'd2,
		KEY_MODE = 2'd3
	} key_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESS_THRESHOLD = 3'd0,
		CFG_GATE_MS         = 3'd1,
		CFG_HOLD_MS         = 3'd2,
		CFG_SLOW_REPEAT_MS  = 3'd3,
		CFG_FAST_REPEAT_MS  = 3'd4,
		CFG_FAST_AFTER      = 3'd5,
		CFG_SLOW_LIMIT      = 3'd6,
		CFG_UNUSED          = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [9:0]  press_threshold;
		logic [15:0] gate_ms;
		logic [15:0] hold_ms;
		logic [15:0] slow_repeat_ms;
		logic [15:0] fast_repeat_ms;
		logic [5:0]  fast_after;
		logic [5:0]  slow_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		press_threshold: 10'd900,
		gate_ms:         16'd100,
		hold_ms:         16'd500,
		slow_repeat_ms:  16'd100,
		fast_repeat_ms:  16'd20,
		fast_after:      6'd15,
		slow_limit:      6'd30
	};

	typedef struct packed {
		logic [31:0] gate_time;
		logic [31:0] repeat_time;
		key_code_t   last_code;
		logic [5:0]  repeat_count;
		logic        mode_bit;
		logic [31:0] count_reg;
		logic        wake_bit;
	} state_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [9:0]  up_level;
		logic [9:0]  down_level;
		logic        mode_pin;
		logic        take_wake;
	} sample_t;

	typedef struct packed {
		key_code_t   key_code;
		logic        acted;
		logic        mode_now;
		logic [31:0] count_value;
		logic        wake_seen;
	} result_t;

endpackage

// File: hw/rtl/barp_step.sv
// ----------------------------------------------------------------------------
// barp_step
// One evaluation step: classify a sample, run gate, press, repeat and release
// rules, and give the next panel state with the result beat.
// ----------------------------------------------------------------------------
module barp_step (
	input  barp_pkg::cfg_t    cfg,
	input  barp_pkg::state_t  st,
	input  barp_pkg::sample_t smp,
	output barp_pkg::state_t  st_next,
	output barp_pkg::result_t res
);
	import barp_pkg::*;

	key_code_t   code;
	logic [31:0] since_gate;
	logic [31:0] since_rep;
	logic        gate_ok;
	logic        hold_ok;
	logic        slow_ok;
	logic        fast_ok;
	logic        fire;
	state_t      s;

	always_comb begin
		if (smp.up_level >= cfg.press_threshold) begin
			code = KEY_UP;
		end else if (smp.down_level >= cfg.press_threshold) begin
			code = KEY_DOWN;
		end else if (smp.mode_pin) begin
			code = KEY_MODE;
		end else begin
			code = KEY_NONE;
		end
	end

	assign since_gate = smp.now_ms - st.gate_time;
	assign since_rep  = smp.now_ms - st.repeat_time;
	assign gate_ok    = since_gate >= {16'd0, cfg.gate_ms};
	assign hold_ok    = since_gate >= {16'd0, cfg.hold_ms};
	assign slow_ok    = (since_rep >= {16'd0, cfg.slow_repeat_ms})
		&& (st.repeat_count <= cfg.slow_limit);
	assign fast_ok    = (since_rep >= {16'd0, cfg.fast_repeat_ms})
		&& (st.repeat_count >= cfg.fast_after);

	always_comb begin
		s    = st;
		fire = 1'b0;
		if (gate_ok) begin
			if (code != st.last_code && code != KEY_NONE) begin
				fire        = 1'b1;
				s.gate_time = smp.now_ms;
			end else if (hold_ok && code == st.last_code && code != KEY_NONE) begin
				if (slow_ok) begin
					fire          = 1'b1;
					s.repeat_time = smp.now_ms;
					if (st.repeat_count != REPEAT_MAX) begin
						s.repeat_count = st.repeat_count + 6'd1;
					end
				end else if (fast_ok) begin
					fire          = 1'b1;
					s.repeat_time = smp.now_ms;
				end
			end else if (code != st.last_code && code == KEY_NONE) begin
				s.gate_time    = smp.now_ms;
				s.repeat_count = 6'd0;
			end
			s.last_code = code;
		end

		// key action: count in mode 1, toggle on mode key, else raise wake
		if (fire) begin
			if (code == KEY_DOWN && st.mode_bit) begin
				s.count_reg = st.count_reg - 32'd1;
			end else if (code == KEY_MODE) begin
				s.mode_bit = ~st.mode_bit;
			end else if (code == KEY_UP && st.mode_bit) begin
				s.count_reg = st.count_reg + 32'd1;
			end else begin
				s.wake_bit = 1'b1;
			end
		end

		res.key_code    = code;
		res.acted       = fire;
		res.mode_now    = s.mode_bit;
		res.count_value = s.count_reg;
		res.wake_seen   = smp.take_wake & s.wake_bit;

		if (smp.take_wake) begin
			s.wake_bit = 1'b0;
		end
		st_next = s;
	end

endmodule

// File: hw/rtl/button_auto_repeat_panel_core.sv
// ----------------------------------------------------------------------------
// button_auto_repeat_panel_core
// Key panel with gate-interval debounce and accelerating auto-repeat.
// ----------------------------------------------------------------------------
// Each sample beat (time stamp, two analog key levels, mode key, wake read)
// yields exactly one result beat. The core takes one sample per clock and
// keeps that rate as long as the result side takes beats; a sample waits in
// the input register until the result register is free or being emptied,
// then the step logic evaluates it against the panel state and writes both
// the state and the result register at the next edge, raising result valid.
// The state loop closes within that single step, which is what sets the
// one-per-cycle rate. Configuration registers (index 0 press_threshold
// through 6 slow_limit) are written through cfg_wen/cfg_index/cfg_wdata and
// must only change while no sample is in flight.
module button_auto_repeat_panel_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [barp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [barp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic [31:0]                          now_ms,
	input  logic [9:0]                           up_level,
	input  logic [9:0]                           down_level,
	input  logic                                 mode_pin,
	input  logic                                 take_wake,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [1:0]                           key_code,
	output logic                                 acted,
	output logic                                 mode_now,
	output logic signed [31:0]                   count_value,
	output logic                                 wake_seen
);
	import barp_pkg::*;

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_next;
	sample_t smp_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;

	// Move the staged sample into the result register when that slot is
	// free or being emptied this cycle.
	assign advance      = valid_s1 && (!res_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	// configuration writes; unknown indexes drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wen) begin
			case (cfg_index_t'(cfg_index))
				CFG_PRESS_THRESHOLD: cfg_q.press_threshold <= cfg_wdata[9:0];
				CFG_GATE_MS:         cfg_q.gate_ms         <= cfg_wdata;
				CFG_HOLD_MS:         cfg_q.hold_ms         <= cfg_wdata;
				CFG_SLOW_REPEAT_MS:  cfg_q.slow_repeat_ms  <= cfg_wdata;
				CFG_FAST_REPEAT_MS:  cfg_q.fast_repeat_ms  <= cfg_wdata;
				CFG_FAST_AFTER:      cfg_q.fast_after      <= cfg_wdata[5:0];
				CFG_SLOW_LIMIT:      cfg_q.slow_limit      <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// input register: hold the sample until the step stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			smp_s1 <= '{now_ms: now_ms, up_level: up_level, down_level: down_level,
				mode_pin: mode_pin, take_wake: take_wake};
		end
	end

	barp_step u_step (
		.cfg     (cfg_q),
		.st      (st_q),
		.smp     (smp_s1),
		.st_next (st_next),
		.res     (res_comb)
	);

	// panel state advances only with a sample that moves to the result side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{gate_time: 32'd0, repeat_time: 32'd0, last_code: KEY_NONE,
				repeat_count: 6'd0, mode_bit: 1'b0, count_reg: 32'd0, wake_bit: 1'b0};
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign result_valid = res_valid_q;
	assign key_code     = res_q.key_code;
	assign acted        = res_q.acted;
	assign mode_now     = res_q.mode_now;
	assign count_value  = $signed(res_q.count_value);
	assign wake_seen    = res_q.wake_seen;

	// Checks on the step pipeline.
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> sample_ready)
		else $error("sample side stalled with an empty result slot");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> st_q == $past(st_q))
		else $error("panel state changed without a step");

	a_count_needs_action: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !res_comb.acted |=> st_q.count_reg == $past(st_q.count_reg))
		else $error("count changed without a key action");

	a_mode_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_comb.acted && res_comb.key_code == KEY_MODE
		|=> st_q.mode_bit != $past(st_q.mode_bit))
		else $error("mode action did not toggle the mode");

	a_wake_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && smp_s1.take_wake |=> !st_q.wake_bit)
		else $error("wake flag not cleared by a read");

endmodule

// File: test/button_auto_repeat_panel_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_auto_repeat_panel_core_tb
// Self-checking bench for the key panel core with debounce and auto-repeat.
// ----------------------------------------------------------------------------
// A short table of directed samples runs first under the reset settings, then
// several register settings (all ones, all zeros, saturating repeats, fast
// acceleration, random, reset values) each get random key sequences: presses
// held for random spans with a drifting time stamp, releases, and noise
// samples. A behavioral model of the panel predicts every result beat; the
// monitor compares each beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module button_auto_repeat_panel_core_tb;

	import barp_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_BEATS = 60;
	localparam int N_DIRECTED  = 22;

	// One row of the directed table: the sample, and a hand-written result
	// that replaces the model's prediction when use_lit is set.
	typedef struct packed {
		sample_t smp;
		logic    use_lit;
		result_t want;
	} row_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_wen      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	logic [31:0]           now_ms       = '0;
	logic [9:0]            up_level     = '0;
	logic [9:0]            down_level   = '0;
	logic                  mode_pin     = 1'b0;
	logic                  take_wake    = 1'b0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [1:0]            key_code;
	logic                  acted;
	logic                  mode_now;
	logic signed [31:0]    count_value;
	logic                  wake_seen;

	button_auto_repeat_panel_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.now_ms       (now_ms),
		.up_level     (up_level),
		.down_level   (down_level),
		.mode_pin     (mode_pin),
		.take_wake    (take_wake),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.key_code     (key_code),
		.acted        (acted),
		.mode_now     (mode_now),
		.count_value  (count_value),
		.wake_seen    (wake_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Panel model: settings and state as the core should hold them
	// ------------------------------------------------------------------
	cfg_t        panel_cfg    = CFG_RESET;
	logic [31:0] eval_stamp   = '0;   // time of the last press or release
	logic [31:0] repeat_stamp = '0;   // time of the last auto-repeat
	key_code_t   prev_key     = KEY_NONE;
	logic [5:0]  repeats      = '0;
	logic        mode_q       = 1'b0;
	logic [31:0] count_q      = '0;
	logic        wake_q       = 1'b0;
	int          fail_count   = 0;

	result_t panel_results_q [$];   // predicted result beats, oldest first

	// Act on one key: step the count in mode 1, toggle on mode, else wake.
	function automatic void fire_key(input key_code_t k);
		if (k == KEY_DOWN && mode_q) begin
			count_q = count_q - 32'd1;
		end else if (k == KEY_MODE) begin
			mode_q = ~mode_q;
		end else if (k == KEY_UP && mode_q) begin
			count_q = count_q + 32'd1;
		end else begin
			wake_q = 1'b1;
		end
	endfunction

	function automatic result_t predict_panel(input sample_t s);
		key_code_t   k;
		logic [31:0] since_eval;
		logic [31:0] since_rep;
		logic        fired;
		result_t     r;

		// Classify with priority up, down, mode.
		if (s.up_level >= panel_cfg.press_threshold) begin
			k = KEY_UP;
		end else if (s.down_level >= panel_cfg.press_threshold) begin
			k = KEY_DOWN;
		end else if (s.mode_pin) begin
			k = KEY_MODE;
		end else begin
			k = KEY_NONE;
		end
		fired = 1'b0;
		since_eval = s.now_ms - eval_stamp;
		// Evaluate only once the gate interval has passed; time wraps at 32 bits.
		if (since_eval >= 32'(panel_cfg.gate_ms)) begin
			if (k != prev_key && k != KEY_NONE) begin
				fire_key(k);
				fired = 1'b1;
				eval_stamp = s.now_ms;
			end else if (since_eval >= 32'(panel_cfg.hold_ms) && k == prev_key &&
			             k != KEY_NONE) begin
				// Held key: slow repeats count up (saturating), fast ones do not.
				since_rep = s.now_ms - repeat_stamp;
				if (since_rep >= 32'(panel_cfg.slow_repeat_ms) &&
				    repeats <= panel_cfg.slow_limit) begin
					fire_key(k);
					fired = 1'b1;
					if (repeats != REPEAT_MAX) begin
						repeats = repeats + 6'd1;
					end
					repeat_stamp = s.now_ms;
				end else if (since_rep >= 32'(panel_cfg.fast_repeat_ms) &&
				             repeats >= panel_cfg.fast_after) begin
					fire_key(k);
					fired = 1'b1;
					repeat_stamp = s.now_ms;
				end
			end else if (k != prev_key && k == KEY_NONE) begin
				eval_stamp = s.now_ms;
				repeats = '0;
			end
			prev_key = k;
		end
		r.key_code    = k;
		r.acted       = fired;
		r.mode_now    = mode_q;
		r.count_value = count_q;
		r.wake_seen   = s.take_wake ? wake_q : 1'b0;
		if (s.take_wake) begin
			wake_q = 1'b0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed table: reset settings (threshold 900, gate 100, hold 500,
	// slow 100, fast 20). Literal results only where plain to see.
	// ------------------------------------------------------------------
	localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// quiet at t=0: gate not yet passed
		'{'{32'd0, 10'd0, 10'd0, 1'b0, 1'b0}, 1'b1, '{KEY_NONE, 1'b0, 1'b0, 32'd0, 1'b0}},
		// first up press in mode 0 sets wake, read it at once
		'{'{32'd100, 10'd1023, 10'd0, 1'b0, 1'b1}, 1'b1, '{KEY_UP, 1'b1, 1'b0, 32'd0, 1'b1}},
		// inside the gate: code reported, no evaluation
		'{'{32'd150, 10'd1023, 10'd1023, 1'b0, 1'b0}, 1'b1, '{KEY_UP, 1'b0, 1'b0, 32'd0, 1'b0}},
		// level exactly at threshold wins for down, up one below
		'{'{32'd200, 10'd899, 10'd900, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'd300, 10'd0, 10'd0, 1'b0, 1'b1}, 1'b0, '0},
		// mode press toggles to mode 1
		'{'{32'd400, 10'd0, 10'd0, 1'b1, 1'b0}, 1'b1, '{KEY_MODE, 1'b1, 1'b1, 32'd0, 1'b0}},
		'{'{32'd500, 10'd0, 10'd0, 1'b0, 1'b0}, 1'b0, '0},
		// down from zero wraps the count
		'{'{32'd600, 10'd0, 10'd1023, 1'b0, 1'b0}, 1'b1,
		  '{KEY_DOWN, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0}},
		// held, hold time not reached
		'{'{32'd700, 10'd0, 10'd1000, 1'b0, 1'b0}, 1'b0, '0},
		// hold reached: first repeat measured from a repeat time never set
		'{'{32'd1100, 10'd0, 10'd1023, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'd1150, 10'd0, 10'd1023, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'd1200, 10'd0, 10'd1023, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'd1300, 10'd0, 10'd0, 1'b0, 1'b0}, 1'b0, '0},
		// up presses walk the count back to zero
		'{'{32'd1400, 10'd1023, 10'd0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'd1500, 10'd0, 10'd0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'd1600, 10'd1023, 10'd0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'd1700, 10'd0, 10'd0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'd1800, 10'd1023, 10'd0, 1'b0, 1'b0}, 1'b0, '0},
		// time stamp wraps past 2^32 across the next rows
		'{'{32'hFFFF_FFF0, 10'd0, 10'd0, 1'b1, 1'b1}, 1'b0, '0},
		'{'{32'h0000_0060, 10'd0, 10'd0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{32'h0000_00D0, 10'd1023, 10'd0, 1'b0, 1'b0}, 1'b0, '0},
		// all keys at once inside the gate, wake read
		'{'{32'h0000_0100, 10'd1023, 10'd1023, 1'b1, 1'b1}, 1'b0, '0}
	};

	// ------------------------------------------------------------------
	// Sample driver: bursts of beats with random gaps between them
	// ------------------------------------------------------------------
	int burst_left = 0;

	task automatic send_sample(input sample_t s, input result_t lit, input logic use_lit);
		int      gap;
		result_t predicted;

		if (burst_left == 0) begin
			// Back-to-back bursts now and then, so some stretches never idle.
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		sample_valid <= 1'b1;
		now_ms       <= s.now_ms;
		up_level     <= s.up_level;
		down_level   <= s.down_level;
		mode_pin     <= s.mode_pin;
		take_wake    <= s.take_wake;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		// The model runs in acceptance order; settings only change while idle.
		predicted = predict_panel(s);
		panel_results_q.push_back(use_lit ? lit : predicted);
		@(negedge clk);
	endtask

	// Drop valid, let every predicted beat arrive, then let the pipe settle.
	task automatic drain_panel();
		sample_valid <= 1'b0;
		while (panel_results_q.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	task automatic load_settings(input cfg_t c);
		write_reg(CFG_PRESS_THRESHOLD, 16'(c.press_threshold));
		write_reg(CFG_GATE_MS,         c.gate_ms);
		write_reg(CFG_HOLD_MS,         c.hold_ms);
		write_reg(CFG_SLOW_REPEAT_MS,  c.slow_repeat_ms);
		write_reg(CFG_FAST_REPEAT_MS,  c.fast_repeat_ms);
		write_reg(CFG_FAST_AFTER,      16'(c.fast_after));
		write_reg(CFG_SLOW_LIMIT,      16'(c.slow_limit));
		cfg_wen <= 1'b0;
		@(negedge clk);
		panel_cfg = c;
	endtask

	// Analog levels on either side of the current threshold.
	function automatic logic [9:0] level_pressed();
		return 10'($urandom_range(1023, int'(panel_cfg.press_threshold)));
	endfunction

	function automatic logic [9:0] level_released();
		if (panel_cfg.press_threshold == 10'd0) begin
			return 10'd0;
		end
		return 10'($urandom_range(int'(panel_cfg.press_threshold) - 1, 0));
	endfunction

	// Sample that classifies as key k (up and down are both possible for up).
	function automatic sample_t make_sample(input key_code_t k, input logic [31:0] t);
		sample_t s;

		s.now_ms     = t;
		s.take_wake  = ($urandom_range(0, 3) == 0);
		s.up_level   = level_released();
		s.down_level = level_released();
		s.mode_pin   = 1'b0;
		case (k)
			KEY_UP: begin
				s.up_level   = level_pressed();
				s.down_level = 10'($urandom);
				s.mode_pin   = 1'($urandom);
			end
			KEY_DOWN: begin
				s.down_level = level_pressed();
				s.mode_pin   = 1'($urandom);
			end
			KEY_MODE: begin
				s.mode_pin = 1'b1;
			end
			default: begin
			end
		endcase
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int          i;
		int          p;
		int          j;
		int          n_sent;
		int          hold_len;
		int          tick;
		cfg_t        c;
		sample_t     s;
		key_code_t   k;
		logic [31:0] stamp_ms;

		// Hold reset, then release it on a falling edge.
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < N_DIRECTED; i++) begin
			send_sample(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].want,
			            DIRECTED_ROWS[i].use_lit);
		end

		stamp_ms = 32'd2000;
		for (p = 0; p < 7; p++) begin
			case (p)
				0: c = '{10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 6'd63};
				1: c = '0;
				// zero intervals, no slow limit: repeat count climbs to saturation
				2: c = '{10'd512, 16'd0, 16'd0, 16'd0, 16'd0, 6'd0, 6'd63};
				// short slow phase, early switch to fast repeats
				3: c = '{10'd600, 16'd5, 16'd40, 16'd10, 16'd3, 6'd4, 6'd8};
				6: c = CFG_RESET;
				default: begin
					c.press_threshold = 10'($urandom_range(0, 1023));
					c.gate_ms         = 16'($urandom_range(0, 300));
					c.hold_ms         = 16'($urandom_range(0, 2000));
					c.slow_repeat_ms  = 16'($urandom_range(0, 300));
					c.fast_repeat_ms  = 16'($urandom_range(0, 100));
					c.fast_after      = 6'($urandom_range(0, 63));
					c.slow_limit      = 6'($urandom_range(0, 63));
				end
			endcase
			drain_panel();
			load_settings(c);
			// Time step sized so gate, hold and repeats all pass within a hold.
			tick = (int'(c.gate_ms > c.slow_repeat_ms ? c.gate_ms : c.slow_repeat_ms) >> 1)
			     + (int'(c.hold_ms) >> 3) + 3;
			if (p == 3) begin
				stamp_ms = 32'hFFFF_FF80;
			end
			n_sent = 0;
			while (n_sent < PHASE_BEATS) begin
				if ($urandom_range(0, 7) == 0) begin
					// Noise: any levels, any keys, a jump anywhere in time.
					s.now_ms     = $urandom;
					s.up_level   = 10'($urandom);
					s.down_level = 10'($urandom);
					s.mode_pin   = 1'($urandom);
					s.take_wake  = 1'($urandom);
					stamp_ms     = s.now_ms;
					send_sample(s, '0, 1'b0);
					n_sent++;
				end else begin
					// Press, hold for a span (now and then long enough to
					// accelerate and saturate), then release.
					k = key_code_t'($urandom_range(1, 3));
					hold_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
					                                      : $urandom_range(1, 12);
					for (j = 0; j < hold_len; j++) begin
						stamp_ms = stamp_ms + 32'($urandom_range(0, tick));
						send_sample(make_sample(k, stamp_ms), '0, 1'b0);
						n_sent++;
					end
					hold_len = $urandom_range(1, 4);
					for (j = 0; j < hold_len; j++) begin
						stamp_ms = stamp_ms + 32'($urandom_range(0, tick));
						send_sample(make_sample(KEY_NONE, stamp_ms), '0, 1'b0);
						n_sent++;
					end
				end
			end
		end

		drain_panel();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: stall pattern of its own, independent of the sender
	// ------------------------------------------------------------------
	int rx_left = 0;
	int rx_mode = 0;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(4, 40);
		end
		rx_left--;
		case (rx_mode)
			0:       result_ready <= 1'b1;
			1:       result_ready <= ($urandom_range(0, 3) != 0);
			default: result_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result beat with the oldest prediction
	// ------------------------------------------------------------------
	result_t beat_got;
	result_t beat_want;

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			beat_got.key_code    = key_code_t'(key_code);
			beat_got.acted       = acted;
			beat_got.mode_now    = mode_now;
			beat_got.count_value = count_value;
			beat_got.wake_seen   = wake_seen;
			if (panel_results_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: result beat with nothing predicted: key %0d", $realtime,
					         key_code);
				end
			end else begin
				beat_want = panel_results_q.pop_front();
				if (beat_got !== beat_want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display({"%0t: mismatch key/acted/mode/count/wake ",
						          "exp %0d/%0d/%0d/%h/%0d got %0d/%0d/%0d/%h/%0d"},
						         $realtime, beat_want.key_code, beat_want.acted,
						         beat_want.mode_now, beat_want.count_value,
						         beat_want.wake_seen, beat_got.key_code, beat_got.acted,
						         beat_got.mode_now, beat_got.count_value,
						         beat_got.wake_seen);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if no beat moves on either side for too long
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

endmodule
